// ----- design/b64_pkg.sv -----
package b64_pkg;

  localparam int FIFO_DEPTH = 4;

  localparam logic [7:0] PAD_CHAR   = 8'h3d;
  localparam logic [7:0] PLUS_CHAR  = 8'h2b;
  localparam logic [7:0] SLASH_CHAR = 8'h2f;

  typedef enum logic [1:0] {
    KIND_DATA       = 2'd0,
    KIND_OK         = 2'd1,
    KIND_BAD_LENGTH = 2'd2,
    KIND_BAD_CHAR   = 2'd3
  } kind_t;

  // one accepted character's worth of results, handed from front to back
  typedef struct packed {
    logic [2:0][7:0] data;
    logic [1:0]      nbytes;
    logic            has_status;
    kind_t           status;
  } job_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } sextet_t;

  function automatic sextet_t sextet_of(input logic [7:0] ch);
    sextet_t s;
    s.valid = 1'b1;
    s.value = 6'd0;
    if (ch >= 8'h41 && ch <= 8'h5a) begin
      s.value = 6'(ch - 8'h41);
    end else if (ch >= 8'h61 && ch <= 8'h7a) begin
      s.value = 6'(ch - 8'h61 + 8'd26);
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      s.value = 6'(ch - 8'h30 + 8'd52);
    end else if (ch == PLUS_CHAR) begin
      s.value = 6'd62;
    end else if (ch == SLASH_CHAR) begin
      s.value = 6'd63;
    end else begin
      s.valid = 1'b0;
    end
    return s;
  endfunction

endpackage

// ----- design/b64_front.sv -----
module b64_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    char_in,
  input  logic          end_of_string,
  output logic          wr_en,
  output b64_pkg::job_t wr_job
);

  logic [1:0]  qp, qp_next;
  logic [1:0]  lm, lm_next;
  logic [17:0] acc, acc_next;
  logic        pad, pad_next;
  logic        bad, bad_next;

  b64_pkg::sextet_t sx;
  logic [1:0]  qp1;
  logic [1:0]  lm1;
  logic [17:0] acc1;
  logic        pad1, bad1;
  logic        full_group, flush;
  logic [23:0] bits;

  always_comb begin
    sx         = b64_pkg::sextet_of(char_in);
    lm1        = lm + 2'd1;
    qp1        = qp;
    acc1       = acc;
    pad1       = pad;
    bad1       = bad;
    full_group = 1'b0;
    flush      = 1'b0;
    if (!pad) begin
      if (char_in == b64_pkg::PAD_CHAR) begin
        pad1  = 1'b1;
        flush = 1'b1;
      end else if (!sx.valid) begin
        bad1 = 1'b1;
      end else if (qp == 2'd3) begin
        full_group = 1'b1;
      end else begin
        acc1 = {acc[11:0], sx.value};
        qp1  = qp + 2'd1;
      end
    end
    // end of string without pad flushes what is still held
    if (end_of_string && !pad1) begin
      flush = 1'b1;
    end
  end

  always_comb begin
    wr_job            = '0;
    wr_job.status     = b64_pkg::KIND_OK;
    bits              = {acc, sx.value};
    if (full_group) begin
      wr_job.data[0] = bits[23:16];
      wr_job.data[1] = bits[15:8];
      wr_job.data[2] = bits[7:0];
      wr_job.nbytes  = 2'd3;
    end else if (flush) begin
      if (qp1 == 2'd2) begin
        wr_job.data[0] = acc1[11:4];
        wr_job.nbytes  = 2'd1;
      end else if (qp1 == 2'd3) begin
        wr_job.data[0] = acc1[17:10];
        wr_job.data[1] = acc1[9:2];
        wr_job.nbytes  = 2'd2;
      end
    end
    if (end_of_string) begin
      wr_job.has_status = 1'b1;
      if (lm1 != 2'd0) begin
        wr_job.status = b64_pkg::KIND_BAD_LENGTH;
      end else if (bad1) begin
        wr_job.status = b64_pkg::KIND_BAD_CHAR;
      end else begin
        wr_job.status = b64_pkg::KIND_OK;
      end
    end
    wr_en = accept && (wr_job.has_status || wr_job.nbytes != 2'd0);
  end

  always_comb begin
    qp_next  = qp1;
    lm_next  = lm1;
    acc_next = acc1;
    pad_next = pad1;
    bad_next = bad1;
    if (full_group || flush) begin
      qp_next  = 2'd0;
      acc_next = '0;
    end
    if (end_of_string) begin
      qp_next  = 2'd0;
      lm_next  = 2'd0;
      acc_next = '0;
      pad_next = 1'b0;
      bad_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qp  <= 2'd0;
      lm  <= 2'd0;
      acc <= '0;
      pad <= 1'b0;
      bad <= 1'b0;
    end else if (accept) begin
      qp  <= qp_next;
      lm  <= lm_next;
      acc <= acc_next;
      pad <= pad_next;
      bad <= bad_next;
    end
  end

  a_string_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_string |=> qp == 2'd0 && lm == 2'd0 && !pad && !bad)
    else $error("state not cleared after end of string");

  a_pad_holds_nothing: assert property (@(posedge clk) disable iff (rst)
    pad |-> qp == 2'd0 && acc == '0)
    else $error("sextets held after pad");

  a_status_only_at_end: assert property (@(posedge clk) disable iff (rst)
    wr_en && wr_job.has_status |-> end_of_string)
    else $error("status result without end of string");

endmodule

// ----- design/b64_fifo.sv -----
module b64_fifo #(
  parameter int DEPTH = b64_pkg::FIFO_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  b64_pkg::job_t wr_job,
  input  logic          rd_en,
  output b64_pkg::job_t rd_job,
  output logic          full,
  output logic          not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  b64_pkg::job_t    mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = count == CNT_W'(DEPTH);
  assign not_empty = count != '0;
  assign rd_job    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !full || rd_en)
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> not_empty)
    else $error("queue underflow");

endmodule

// ----- design/b64_back.sv -----
module b64_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_not_empty,
  input  b64_pkg::job_t q_job,
  output logic          q_rd,
  input  logic          pop,
  output logic          empty,
  output logic [7:0]    byte_value,
  output logic [1:0]    kind,
  output logic          last_of_run
);

  b64_pkg::job_t job;
  logic          busy;
  logic [1:0]    idx, idx_next;
  logic [2:0]    total;
  logic          done, take;

  assign empty = !busy;
  assign total = {1'b0, job.nbytes} + {2'b00, job.has_status};
  assign last_of_run = {1'b0, idx} == total - 3'd1;
  assign take  = pop && busy;
  assign done  = take && last_of_run;
  assign q_rd  = q_not_empty && (!busy || done);

  always_comb begin
    if (idx < job.nbytes) begin
      byte_value = job.data[idx];
      kind       = b64_pkg::KIND_DATA;
    end else begin
      byte_value = 8'd0;
      kind       = job.status;
    end
  end

  always_comb begin
    idx_next = idx;
    if (q_rd || done) begin
      idx_next = 2'd0;
    end else if (take) begin
      idx_next = idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      job <= q_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else begin
      idx <= idx_next;
      if (q_rd) begin
        busy <= 1'b1;
      end else if (done) begin
        busy <= 1'b0;
      end
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> {1'b0, idx} < total)
    else $error("result index beyond job");

endmodule

// ----- design/base64_stream_decoder.sv -----
// Streaming base64 decoder, one character per transfer.
// Input side is a queue write port: drive char_in and end_of_string with push;
// the character is taken at a clock edge where push is high and full is low.
// Result side is a queue read port: while empty is low, byte_value, kind and
// last_of_run show the oldest result; pop high with empty low takes it.
// kind is data, end ok, end bad length or end bad character; the status
// comes after the data of the string's last character, so data bytes of a
// string that ends in a bad status should be discarded.
// Throughput: one character per cycle on the input while full is low;
// results leave one per cycle while pop is high. Four characters give
// three bytes, all written with the fourth character; a last character
// with tail and status may give up to four results.
// A character's results are written into the job queue at the edge that
// took it, then loaded into the result register once that register is free.
// When the receiver stalls, jobs pile up in the job queue and full rises
// once it holds FIFO_DEPTH jobs; no result is ever dropped.
// Reset (synchronous, rst high) empties the queue and clears decoder state.
module base64_stream_decoder #(
  parameter int FIFO_DEPTH = b64_pkg::FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_in,
  input  logic       end_of_string,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] byte_value,
  output logic [1:0] kind,
  output logic       last_of_run
);

  logic          accept;
  logic          wr_en, rd_en, q_not_empty;
  b64_pkg::job_t wr_job, rd_job;

  assign accept = push && !full;

  b64_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .char_in       (char_in),
    .end_of_string (end_of_string),
    .wr_en         (wr_en),
    .wr_job        (wr_job)
  );

  b64_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_job    (wr_job),
    .rd_en     (rd_en),
    .rd_job    (rd_job),
    .full      (full),
    .not_empty (q_not_empty)
  );

  b64_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_job       (rd_job),
    .q_rd        (rd_en),
    .pop         (pop),
    .empty       (empty),
    .byte_value  (byte_value),
    .kind        (kind),
    .last_of_run (last_of_run)
  );

endmodule
